>>> src/brp4_pkg.sv
// Shared types and constants for the 4x4 block RMS mosaic.
// Holds the payload structs, controller/datapath interface structs and the FSM enum.
// No dependencies.
package brp4_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int TILE_SIZE  = 4;
    localparam int TILE_COLS  = MAX_WIDTH / TILE_SIZE;
    localparam int TILE_IDX_W = $clog2(TILE_COLS);

    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_DATA_W = 13;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;

    localparam int SUM_W      = 20;
    localparam int SQ_W       = 16;
    localparam int ROOT_STEPS = 10;
    localparam int STEP_W     = 4;
    localparam int NUM_CHAN   = 3;

    // Register indexes on the configuration port
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1024);

    typedef struct packed {
        logic [7:0] blue_value;
        logic [7:0] green_value;
        logic [7:0] red_value;
    } pixel_t;

    typedef struct packed {
        logic [7:0] tile_column;
        logic [9:0] tile_row;
        logic [7:0] blue_level;
        logic [7:0] green_level;
        logic [7:0] red_level;
        logic       last_tile;
    } tile_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_ROOT,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic              load;
        logic              accum;
        logic              root_step;
        logic [STEP_W-1:0] root_index;
        logic              publish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic emit;
        logic out_free;
    } dp_status_t;

endpackage

>>> src/brp4_ctrl.sv
// Sequencer for the 4x4 block RMS mosaic.
// Depends on brp4_pkg for the state enum and the command/status structs.
module brp4_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  brp4_pkg::dp_status_t  status,
    output brp4_pkg::ctrl_cmd_t   cmd
);
    import brp4_pkg::*;

    ctrl_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              last_step;

    assign last_step = (step_reg == STEP_W'(ROOT_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                step_next = '0;
                if (status.emit)
                    state_next = ST_ROOT;
                else
                    state_next = ST_IDLE;
            end
            ST_ROOT:
            begin
                step_next = step_reg + STEP_W'(1);
                if (last_step)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd            = '0;
        cmd.root_index = step_reg;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_ACCUM:
            begin
                cmd.accum = 1'b1;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.publish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> src/brp4_datapath.sv
// Datapath for the 4x4 block RMS mosaic: config registers, raster counters,
// tile-column sum memory, three bit-pair square root lanes and the output register.
// Depends on brp4_pkg.
module brp4_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [brp4_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  brp4_pkg::pixel_t                    in_data,
    input  brp4_pkg::ctrl_cmd_t                 cmd,
    output brp4_pkg::dp_status_t                status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output brp4_pkg::tile_t                     out_data
);
    import brp4_pkg::*;

    localparam logic [SUM_W-1:0] ROOT_TOP_BIT = SUM_W'(1) << (SUM_W - 2);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [3*SUM_W-1:0] mem [TILE_COLS];
    logic [3*SUM_W-1:0] mem_rd_reg;
    logic [3*SUM_W-1:0] mem_wr;

    logic [SQ_W-1:0]  sq_reg   [NUM_CHAN];
    logic [SUM_W-1:0] sum_comb [NUM_CHAN];
    logic [SUM_W-1:0] rem_reg  [NUM_CHAN];
    logic [SUM_W-1:0] root_reg [NUM_CHAN];
    logic [SUM_W-1:0] rem_next [NUM_CHAN];
    logic [SUM_W-1:0] root_next[NUM_CHAN];
    logic [SUM_W-1:0] root_bit;

    logic               tile_start;
    logic               emit;
    logic               last_hit;
    logic [WIDTH_W-1:0] col_inc;
    logic [ROW_W:0]     row_inc;

    logic [7:0] tcol_reg;
    logic [9:0] trow_reg;
    logic       last_reg;

    logic   out_valid_reg;
    tile_t  out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // Clamp dimensions into their legal range
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WIDTH_W'(1);
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
            w_eff = WIDTH_W'(MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = HEIGHT_W'(1);
        else if (height_reg > HEIGHT_W'(MAX_HEIGHT))
            h_eff = HEIGHT_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // Squares of the incoming pixel, registered at accept
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sq_reg[0] <= SQ_W'(in_data.blue_value)  * SQ_W'(in_data.blue_value);
            sq_reg[1] <= SQ_W'(in_data.green_value) * SQ_W'(in_data.green_value);
            sq_reg[2] <= SQ_W'(in_data.red_value)   * SQ_W'(in_data.red_value);
        end
    end

    // Tile-column sum memory: read at accept, write back during accumulate
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            mem_rd_reg <= mem[col_reg[COL_W-1:2]];
        if (cmd.accum)
            mem[col_reg[COL_W-1:2]] <= mem_wr;
    end

    assign tile_start = (row_reg[1:0] == 2'd0) && (col_reg[1:0] == 2'd0);

    always_comb
    begin
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            if (tile_start)
                sum_comb[i] = SUM_W'(sq_reg[i]);
            else
                sum_comb[i] = mem_rd_reg[i*SUM_W +: SUM_W] + SUM_W'(sq_reg[i]);
        end
        mem_wr = {sum_comb[2], sum_comb[1], sum_comb[0]};
    end

    assign emit = (col_reg[1:0] == 2'd3) && (row_reg[1:0] == 2'd3)
                  && ({1'b0, col_reg} < w_eff) && ({1'b0, row_reg} < h_eff);

    assign last_hit = (({1'b0, col_reg[COL_W-1:2]} + 9'd1) == w_eff[WIDTH_W-1:2])
                      && (({1'b0, row_reg[ROW_W-1:2]} + 11'd1) == h_eff[HEIGHT_W-1:2]);

    // Raster counters; wrap at the current limits
    assign col_inc = {1'b0, col_reg} + WIDTH_W'(1);
    assign row_inc = {1'b0, row_reg} + HEIGHT_W'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            if (row_inc >= h_eff)
                row_next = '0;
            else
                row_next = row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.accum)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Square root lanes, one bit pair per step
    assign root_bit = ROOT_TOP_BIT >> {cmd.root_index, 1'b0};

    always_comb
    begin
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            if (rem_reg[i] >= root_reg[i] + root_bit)
            begin
                rem_next[i]  = rem_reg[i] - (root_reg[i] + root_bit);
                root_next[i] = (root_reg[i] >> 1) + root_bit;
            end
            else
            begin
                rem_next[i]  = rem_reg[i];
                root_next[i] = root_reg[i] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accum)
        begin
            for (int i = 0; i < NUM_CHAN; i++)
            begin
                rem_reg[i]  <= sum_comb[i];
                root_reg[i] <= '0;
            end
            tcol_reg <= col_reg[COL_W-1:2];
            trow_reg <= row_reg[ROW_W-1:2];
            last_reg <= last_hit;
        end
        else if (cmd.root_step)
        begin
            for (int i = 0; i < NUM_CHAN; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.publish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_data_reg.tile_column <= tcol_reg;
            out_data_reg.tile_row    <= trow_reg;
            out_data_reg.blue_level  <= root_reg[0][9:2];
            out_data_reg.green_level <= root_reg[1][9:2];
            out_data_reg.red_level   <= root_reg[2][9:2];
            out_data_reg.last_tile   <= last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign status.emit     = emit;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

>>> src/block_rms_pixelate_4x4_top.sv
// Top level of the 4x4 block RMS mosaic; joins controller and datapath.
// Depends on brp4_pkg, brp4_ctrl and brp4_datapath.
// Sequence: a pixel that does not finish a tile passes through accept and accumulate.
// A tile-finishing pixel passes through accept, accumulate, 10 square root steps and publish;
// publish waits while the output stalls, and no new pixel is taken until the sequence ends.
// Reset: counters clear to 0, width and height to 1024; the sum memory is not cleared.
module block_rms_pixelate_4x4_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [brp4_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  brp4_pkg::pixel_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output brp4_pkg::tile_t                   out_data
);
    import brp4_pkg::*;

    // Commands from the sequencer and status from the datapath
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer: accepts a pixel request only when idle, then walks it through accumulate and,
    // for a tile-finishing pixel, the root steps and the publish into the output register.
    brp4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: holds the raster position, the per-tile-column running sums,
    // the square root lanes and the output register that parts the result
    // from the pixel side, so a finished tile can wait while pixels flow.
    brp4_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> src/brp4_checker.sv
// Port-level checks for the 4x4 block RMS mosaic, bound to the top level.
// Depends on brp4_pkg and block_rms_pixelate_4x4_top.
module brp4_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [brp4_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  brp4_pkg::pixel_t                  in_data,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  brp4_pkg::tile_t                   out_data
);
    import brp4_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // Drop ready for at least the accumulate cycle after each pixel
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("pixel accepted while previous one accumulates");

    // A new result is published only while no pixel request can be taken
    a_publish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result published while idle");

endmodule

bind block_rms_pixelate_4x4_top brp4_checker u_brp4_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for block_rms_pixelate_4x4_top: raster pixels in, 4x4 tile RMS out.
// Depends on brp4_pkg and the block's RTL; a built-in predictor supplies the expected tiles.
module testbench;
    import brp4_pkg::*;

    // Cycles to let pass after the last expected tile before touching the registers:
    // a pixel that finishes no tile is still in flight for its accumulate cycle.
    localparam int SETTLE_CYCLES = 16;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    pixel_t                in_data;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    tile_t                 out_data;

    block_rms_pixelate_4x4_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Predictor state: per-tile-column squared sums, raster counters, register copies.
    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } square_sums_t;

    square_sums_t        tile_sums [TILE_COLS];
    int                  col_count;
    int                  row_count;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    tile_t pending_tiles [$];   // expected tiles, oldest first
    int    error_count;
    int    pixel_total;
    int    tile_total;
    bit    allow_idle;          // random bubbles on both sides while set
    int    sink_stall;

    // Floor square root, built bit by bit from the top of a 10-bit root.
    function automatic int floor_sqrt(input int value);
        int root;
        int trial;
        root = 0;
        for (int b = 9; b >= 0; b--)
        begin
            trial = root | (1 << b);
            if (trial * trial <= value)
                root = trial;
        end
        return root;
    endfunction

    // Advance the predictor by one accepted pixel; queue the tile it finishes, if any.
    task automatic predict_pixel(input pixel_t px);
        int           eff_w;
        int           eff_h;
        int           tc;
        square_sums_t acc;
        tile_t        tile;
        // Clamp the registers to the ranges the block honors.
        if (width_reg == 0)
            eff_w = 1;
        else if (width_reg > MAX_WIDTH)
            eff_w = MAX_WIDTH;
        else
            eff_w = int'(width_reg);
        if (height_reg == 0)
            eff_h = 1;
        else if (height_reg > MAX_HEIGHT)
            eff_h = MAX_HEIGHT;
        else
            eff_h = int'(height_reg);

        tc = (col_count / TILE_SIZE) % TILE_COLS;
        // The top-left pixel of a tile restarts its sums.
        if ((row_count % TILE_SIZE) == 0 && (col_count % TILE_SIZE) == 0)
            acc = '0;
        else
            acc = tile_sums[tc];
        acc.blue  = acc.blue  + px.blue_value  * px.blue_value;
        acc.green = acc.green + px.green_value * px.green_value;
        acc.red   = acc.red   + px.red_value   * px.red_value;
        tile_sums[tc] = acc;

        // Only the bottom-right pixel of a tile inside the cropped frame reports.
        if ((row_count % TILE_SIZE) == TILE_SIZE - 1 && (col_count % TILE_SIZE) == TILE_SIZE - 1 &&
            col_count < eff_w && row_count < eff_h)
        begin
            tile.tile_column = 8'(tc);
            tile.tile_row    = 10'(row_count / TILE_SIZE);
            tile.blue_level  = 8'(floor_sqrt(int'(acc.blue)) / 4);
            tile.green_level = 8'(floor_sqrt(int'(acc.green)) / 4);
            tile.red_level   = 8'(floor_sqrt(int'(acc.red)) / 4);
            tile.last_tile   = (col_count == (eff_w / TILE_SIZE) * TILE_SIZE - 1) &&
                               (row_count == (eff_h / TILE_SIZE) * TILE_SIZE - 1);
            pending_tiles.push_back(tile);
            tile_total++;
        end
        pixel_total++;

        // Wrap the column at the row end and the row at the frame end.
        col_count++;
        if (col_count >= eff_w)
        begin
            col_count = 0;
            row_count++;
            if (row_count >= eff_h)
                row_count = 0;
        end
    endtask

    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        px.blue_value  = random_channel();
        px.green_value = random_channel();
        px.red_value   = random_channel();
        return px;
    endfunction

    // Offer one pixel request, maybe after a short bubble, and hold it until accepted.
    // Valid stays high on return so the next request can follow back to back.
    task automatic send_pixel(input pixel_t px);
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do
            @(posedge clk);
        while (!in_ready);
        predict_pixel(px);
    endtask

    // Drop valid, hold off until every expected tile has come, then let the pipe settle.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_tiles.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register while the block is quiet; the predictor takes the same masking.
    task automatic write_reg(input logic reg_index, input logic [CFG_DATA_W-1:0] value);
        wait_for_drain();
        cfg_we    <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (reg_index == REG_IMAGE_WIDTH)
            width_reg = value[WIDTH_W-1:0];
        else
            height_reg = value[HEIGHT_W-1:0];
    endtask

    task automatic set_frame(input int width, input int height);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(width));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(height));
    endtask

    // Send random pixels until the raster counters are back at the frame start.
    task automatic finish_frame();
        while (col_count != 0 || row_count != 0)
            send_pixel(random_pixel());
    endtask

    task automatic run_frame();
        send_pixel(random_pixel());
        finish_frame();
    endtask

    // One 4x4 tile: blue saturated, green zero, red sweeping the full range.
    task automatic test_channel_extremes();
        pixel_t px;
        set_frame(4, 4);
        for (int i = 0; i < 16; i++)
        begin
            px.blue_value  = 8'd255;
            px.green_value = 8'd0;
            px.red_value   = 8'(i * 17);
            send_pixel(px);
        end
        wait_for_drain();
    endtask

    // Images too small for a tile, zero-sized registers, and cropped edges.
    task automatic test_tiny_images();
        set_frame(3, 8);
        run_frame();
        set_frame(0, 0);
        repeat (3) run_frame();
        set_frame(4, 0);
        run_frame();
        set_frame(8, 3);
        run_frame();
        // Right and bottom partial tiles drop out; one full tile remains.
        set_frame(6, 6);
        run_frame();
        wait_for_drain();
    endtask

    // A single 24-pixel row: no tile completes, and every tile column that the
    // random frames reach starts its sums here.
    task automatic test_widest_frame();
        set_frame(24, 1);
        run_frame();
        wait_for_drain();
    endtask

    // Register writes in the middle of a frame: counters keep going and wrap at the new limits.
    task automatic test_mid_frame_writes();
        set_frame(1024, 8);
        repeat (6) send_pixel(random_pixel());
        // Column is already past the new width: the row ends after the next pixel.
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(4));
        repeat (13) send_pixel(random_pixel());
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(4096));
        repeat (8) send_pixel(random_pixel());
        // Row is already past the new height: the frame ends with this row.
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
        repeat (4) send_pixel(random_pixel());
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(4));
        run_frame();
        wait_for_drain();
    endtask

    // Random frame sizes with random content, some broken by a mid-frame register write.
    task automatic test_random_frames(input int item_goal, input int tile_goal);
        int                    start_pixels;
        int                    start_tiles;
        int                    width;
        int                    height;
        logic [CFG_DATA_W-1:0] width_data;
        start_pixels = pixel_total;
        start_tiles  = tile_total;
        while (pixel_total - start_pixels < item_goal || tile_total - start_tiles < tile_goal)
        begin
            case ($urandom_range(0, 9))
                0:       width = 0;
                1:       width = $urandom_range(1, 3);
                2:       width = TILE_SIZE * $urandom_range(1, 6);
                default: width = $urandom_range(4, 24);
            endcase
            case ($urandom_range(0, 9))
                0:       height = 0;
                1:       height = $urandom_range(1, 3);
                2:       height = TILE_SIZE * $urandom_range(1, 3);
                default: height = $urandom_range(4, 12);
            endcase
            // Now and then set bits above the width register; they must be dropped.
            width_data = CFG_DATA_W'(width);
            if ($urandom_range(0, 7) == 0)
                width_data[CFG_DATA_W-1:WIDTH_W] = 2'($urandom_range(1, 3));
            write_reg(REG_IMAGE_WIDTH, width_data);
            write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(height));
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 40)) send_pixel(random_pixel());
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, 24)));
                else
                    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 12)));
                finish_frame();
            end
            else
                run_frame();
        end
        wait_for_drain();
    endtask

    // Closing stretch at full rate: no bubbles on either side.
    task automatic test_full_rate();
        allow_idle = 1'b0;
        test_random_frames(150, 8);
    endtask

    // Sink side: stall in bursts of random length while idling is allowed.
    always @(posedge clk)
    begin
        if (allow_idle && sink_stall == 0 && $urandom_range(0, 5) == 0)
            sink_stall = $urandom_range(1, 4);
        if (allow_idle && sink_stall > 0)
        begin
            out_ready <= 1'b0;
            sink_stall--;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Compare each accepted tile against the oldest expectation.
    always @(posedge clk)
    begin : check_tiles
        tile_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_tiles.size() == 0)
            begin
                $error("tile result with none expected: column %0d row %0d",
                       out_data.tile_column, out_data.tile_row);
                error_count++;
            end
            else
            begin
                want = pending_tiles.pop_front();
                check_field("tile_column", 32'(want.tile_column), 32'(out_data.tile_column));
                check_field("tile_row", 32'(want.tile_row), 32'(out_data.tile_row));
                check_field("blue_level", 32'(want.blue_level), 32'(out_data.blue_level));
                check_field("green_level", 32'(want.green_level), 32'(out_data.green_level));
                check_field("red_level", 32'(want.red_level), 32'(out_data.red_level));
                check_field("last_tile", 32'(want.last_tile), 32'(out_data.last_tile));
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_IMAGE_WIDTH;
        cfg_data    = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        allow_idle  = 1'b1;
        sink_stall  = 0;
        error_count = 0;
        pixel_total = 0;
        tile_total  = 0;
        col_count   = 0;
        row_count   = 0;
        width_reg   = WIDTH_RESET;
        height_reg  = HEIGHT_RESET;

        // Hold reset, then release it on an edge.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_channel_extremes();
        test_tiny_images();
        test_widest_frame();
        test_mid_frame_writes();
        test_random_frames(770, 48);
        test_full_rate();

        // Drain whatever is left and give any stray result time to show up.
        wait_for_drain();
        if (error_count == 0)
            $display("block_rms_pixelate_4x4_top test passed");
        else
            $display("block_rms_pixelate_4x4_top test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #50_000_000;
        $display("block_rms_pixelate_4x4_top test failed");
        $finish;
    end

endmodule
